/* rtl/plm_pkg.sv */
package plm_pkg;

	// Field widths of the stream words
	localparam int OP_W       = 3;
	localparam int LIST_W     = 3;
	localparam int PAGE_W     = 10;
	localparam int STATUS_W   = 2;
	localparam int PAGE_OUT_W = 11;
	localparam int COUNT_W    = 11;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	// Default geometry
	localparam int DEF_PAGE_COUNT = 1024;
	localparam int DEF_LIST_COUNT = 8;

	// List counts saturate at the top of the count field
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ADD_HEAD = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_TAIL = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
	localparam logic [OP_W-1:0] OP_MOVE_ALL = 3'd3;
	localparam logic [OP_W-1:0] OP_POP_HEAD = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SAME  = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clr;       // clearing pass: write "none" at the sweep address
		logic capture;   // take the input word
		logic ld_a;      // read list A registers
		logic ld_b;      // read list B registers
		logic rd_link;   // read both link tables
		logic exec;      // apply the operation
		logic fin;       // detach the unlinked page
		logic out_load;  // move the result into the output register
	} plm_cmd_t;

endpackage

/* rtl/plm_ctrl.sv */
module plm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             clr_done,
	output plm_pkg::plm_cmd_t cmd
);
	import plm_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RD_A,
		S_RD_B,
		S_EXEC,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.clr      = (state_q == S_CLEAR);
		cmd.capture  = (state_q == S_IDLE) && in_valid;
		cmd.ld_a     = (state_q == S_RD_A);
		cmd.ld_b     = (state_q == S_RD_B);
		cmd.rd_link  = (state_q == S_RD_B);
		cmd.exec     = (state_q == S_EXEC);
		cmd.fin      = (state_q == S_FIN);
		cmd.out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (clr_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RD_A;
					end
				end
				S_RD_A:  state_q <= S_RD_B;
				S_RD_B:  state_q <= S_EXEC;
				S_EXEC:  state_q <= S_FIN;
				S_FIN: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// An accepted word always walks the same fixed sequence of states.
	ap_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_RD_A) ##3 (state_q == S_FIN))
		else $error("operation sequence broken");

	// A result still waiting holds the next one back.
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) && out_valid_q && !out_ready |=> (state_q == S_FIN))
		else $error("result overwritten while stalled");

	// The clearing pass runs once after reset only.
	ap_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |=> (state_q != S_CLEAR))
		else $error("clearing pass re-entered");

	ap_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

/* rtl/plm_datapath.sv */
module plm_datapath #(
	parameter int PAGE_COUNT = plm_pkg::DEF_PAGE_COUNT,
	parameter int LIST_COUNT = plm_pkg::DEF_LIST_COUNT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  plm_pkg::plm_cmd_t                cmd,
	input  logic [plm_pkg::IN_TDATA_W-1:0]   in_tdata,
	output logic [plm_pkg::OUT_TDATA_W-1:0]  out_tdata,
	output logic                             clr_done
);
	import plm_pkg::*;

	localparam int PW = $clog2(PAGE_COUNT + 1);
	localparam int AW = $clog2(PAGE_COUNT);
	localparam int LW = $clog2(LIST_COUNT);
	localparam logic [PW-1:0] NONE = PW'(PAGE_COUNT);

	typedef logic [PW-1:0]      link_t;
	typedef logic [AW-1:0]      addr_t;
	typedef logic [COUNT_W-1:0] cnt_t;

	function automatic logic is_page(input link_t x);
		return x < NONE;
	endfunction

	function automatic cnt_t sat_add(input cnt_t x, input cnt_t y);
		logic [COUNT_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
	endfunction

	// Link tables, swept to "none" after reset
	link_t next_mem [PAGE_COUNT];
	link_t prev_mem [PAGE_COUNT];

	// List registers
	link_t head_q  [LIST_COUNT];
	link_t tail_q  [LIST_COUNT];
	cnt_t  count_q [LIST_COUNT];

	addr_t clr_q;

	logic [OP_W-1:0]   op_q;
	logic [LIST_W-1:0] a_q, b_q;
	logic [PAGE_W-1:0] p_q;
	link_t hd_a_q, tl_a_q, hd_b_q, tl_b_q;
	cnt_t  ct_a_q, ct_b_q;
	link_t rn_q, rv_q;
	logic  unlink_q;
	addr_t ul_addr_q;
	logic [STATUS_W-1:0]   res_status_q, out_status_q;
	logic [PAGE_OUT_W-1:0] res_page_q, out_page_q;
	cnt_t                  res_count_q, out_count_q;

	logic [LW-1:0] lsel, la, lb;
	addr_t rd_addr;
	logic  a_ok, b_ok, p_ok;
	link_t p_link;

	logic  ex_nx_we, ex_pv_we;
	addr_t ex_nx_wa, ex_pv_wa;
	link_t ex_nx_wd, ex_pv_wd;
	logic  nx_we, pv_we;
	addr_t nx_wa, pv_wa;
	link_t nx_wd, pv_wd;

	link_t new_hd_a, new_tl_a, popped, ul_page;
	cnt_t  new_ct_a;
	logic  clr_b, unlink;
	logic [STATUS_W-1:0] status;

	assign la     = LW'(a_q);
	assign lb     = LW'(b_q);
	assign lsel   = cmd.ld_b ? lb : la;
	assign a_ok   = 32'(a_q) < 32'(LIST_COUNT);
	assign b_ok   = 32'(b_q) < 32'(LIST_COUNT);
	assign p_ok   = 32'(p_q) < 32'(PAGE_COUNT);
	assign p_link = PW'(p_q);
	assign rd_addr = (op_q == OP_POP_HEAD) ? hd_a_q[AW-1:0] : AW'(p_q);

	assign clr_done = (clr_q == AW'(PAGE_COUNT - 1));

	// Operation decode on the gathered operands
	always_comb begin
		ex_nx_we = 1'b0;
		ex_pv_we = 1'b0;
		ex_nx_wa = '0;
		ex_pv_wa = '0;
		ex_nx_wd = NONE;
		ex_pv_wd = NONE;
		new_hd_a = hd_a_q;
		new_tl_a = tl_a_q;
		new_ct_a = ct_a_q;
		clr_b    = 1'b0;
		unlink   = 1'b0;
		ul_page  = p_link;
		popped   = NONE;
		status   = ST_OK;
		if (a_ok) begin
			unique case (op_q)
				OP_ADD_HEAD, OP_ADD_TAIL: begin
					if (p_ok) begin
						if (ct_a_q != '0) begin
							new_ct_a = sat_add(ct_a_q, cnt_t'(1));
							if (op_q == OP_ADD_HEAD) begin
								ex_nx_we = 1'b1;
								ex_nx_wa = AW'(p_q);
								ex_nx_wd = hd_a_q;
								ex_pv_we = is_page(hd_a_q);
								ex_pv_wa = hd_a_q[AW-1:0];
								ex_pv_wd = p_link;
								new_hd_a = p_link;
							end else begin
								ex_nx_we = is_page(tl_a_q);
								ex_nx_wa = tl_a_q[AW-1:0];
								ex_nx_wd = p_link;
								ex_pv_we = 1'b1;
								ex_pv_wa = AW'(p_q);
								ex_pv_wd = tl_a_q;
								new_tl_a = p_link;
							end
						end else begin
							new_hd_a = p_link;
							new_tl_a = p_link;
							new_ct_a = cnt_t'(1);
						end
					end
				end
				OP_REMOVE, OP_POP_HEAD: begin
					if (op_q == OP_REMOVE && !p_ok) begin
						unlink = 1'b0;
					end else if (ct_a_q == '0
							|| (op_q == OP_POP_HEAD && !is_page(hd_a_q))) begin
						status = ST_EMPTY;
					end else begin
						unlink = 1'b1;
						if (op_q == OP_POP_HEAD) begin
							popped  = hd_a_q;
							ul_page = hd_a_q;
						end
						// Neighbours of the page leaving the list
						if (rn_q != NONE) begin
							ex_pv_we = is_page(rn_q);
							ex_pv_wa = rn_q[AW-1:0];
							ex_pv_wd = rv_q;
						end else begin
							new_tl_a = rv_q;
						end
						if (rv_q != NONE) begin
							ex_nx_we = is_page(rv_q);
							ex_nx_wa = rv_q[AW-1:0];
							ex_nx_wd = rn_q;
						end else begin
							new_hd_a = rn_q;
						end
						new_ct_a = ct_a_q - cnt_t'(1);
					end
				end
				OP_MOVE_ALL: begin
					if (b_ok) begin
						if (a_q == b_q) begin
							status = ST_SAME;
						end else begin
							clr_b = 1'b1;
							if (ct_a_q != '0) begin
								if (ct_b_q != '0) begin
									ex_nx_we = is_page(tl_a_q);
									ex_nx_wa = tl_a_q[AW-1:0];
									ex_nx_wd = hd_b_q;
									ex_pv_we = is_page(hd_b_q);
									ex_pv_wa = hd_b_q[AW-1:0];
									ex_pv_wd = tl_a_q;
									new_tl_a = tl_b_q;
									new_ct_a = sat_add(ct_a_q, ct_b_q);
								end
							end else begin
								new_hd_a = hd_b_q;
								new_tl_a = tl_b_q;
								new_ct_a = ct_b_q;
							end
						end
					end
				end
				default: status = ST_OK;
			endcase
		end
	end

	// Write port selection for both link tables
	always_comb begin
		if (cmd.clr) begin
			nx_we = 1'b1;
			nx_wa = clr_q;
			nx_wd = NONE;
			pv_we = 1'b1;
			pv_wa = clr_q;
			pv_wd = NONE;
		end else if (cmd.exec) begin
			nx_we = ex_nx_we;
			nx_wa = ex_nx_wa;
			nx_wd = ex_nx_wd;
			pv_we = ex_pv_we;
			pv_wa = ex_pv_wa;
			pv_wd = ex_pv_wd;
		end else begin
			nx_we = cmd.fin && unlink_q;
			nx_wa = ul_addr_q;
			nx_wd = NONE;
			pv_we = cmd.fin && unlink_q;
			pv_wa = ul_addr_q;
			pv_wd = NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		if (cmd.rd_link) begin
			rn_q <= next_mem[rd_addr];
			rv_q <= prev_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			for (int i = 0; i < LIST_COUNT; i++) begin
				head_q[i]  <= NONE;
				tail_q[i]  <= NONE;
				count_q[i] <= '0;
			end
		end else begin
			if (cmd.clr && !clr_done) begin
				clr_q <= clr_q + addr_t'(1);
			end
			if (cmd.exec && a_ok) begin
				head_q[la]  <= new_hd_a;
				tail_q[la]  <= new_tl_a;
				count_q[la] <= new_ct_a;
			end
			if (cmd.exec && clr_b) begin
				head_q[lb]  <= NONE;
				tail_q[lb]  <= NONE;
				count_q[lb] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= in_tdata[2:0];
			a_q  <= in_tdata[5:3];
			b_q  <= in_tdata[8:6];
			p_q  <= in_tdata[18:9];
		end
		if (cmd.ld_a) begin
			hd_a_q <= head_q[lsel];
			tl_a_q <= tail_q[lsel];
			ct_a_q <= count_q[lsel];
		end
		if (cmd.ld_b) begin
			hd_b_q <= head_q[lsel];
			tl_b_q <= tail_q[lsel];
			ct_b_q <= count_q[lsel];
		end
		if (cmd.exec) begin
			unlink_q     <= unlink;
			ul_addr_q    <= ul_page[AW-1:0];
			res_status_q <= status;
			res_page_q   <= PAGE_OUT_W'(popped);
			res_count_q  <= a_ok ? new_ct_a : '0;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_page_q   <= res_page_q;
			out_count_q  <= res_count_q;
		end
	end

	assign out_tdata = {out_count_q, out_page_q, out_status_q};

endmodule

/* rtl/page_list_manager.sv */
// Page list manager: keeps several doubly linked lists of pages in two tables
// of next and previous links, with a head, a tail and a page count per list.
// Each input word on the slave stream asks for one operation (add at the
// head, add at the tail, remove a page, move a whole list onto another, pop
// the head) and gives exactly one result word on the master stream: a status
// code, the popped page or "none", and the count of the target list after
// the operation. "None" is the value PAGE_COUNT in every link and page field.
// After reset the block sweeps the link tables to "none", one entry per
// cycle, and tready stays low until all PAGE_COUNT entries (1024 by
// default) are swept. An item walks these states in order: acceptance, a
// read of list A's registers, a read of list B's registers together with
// the link table read, the update, and a final state that detaches the
// unlinked page and hands over the result. No new word is taken until the
// result of the last one has moved into the output register; the
// controller walks the same five states for every operation.
// The result waits in an output register, so a stalled receiver holds the
// block in its final cycle only until the word there is taken.
module page_list_manager #(
	parameter int PAGE_COUNT = plm_pkg::DEF_PAGE_COUNT,
	parameter int LIST_COUNT = plm_pkg::DEF_LIST_COUNT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// op[2:0], list_a[5:3], list_b[8:6], page[18:9], zero fill above
	input  logic [plm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// status[1:0], page_out[12:2], count_out[23:13]
	output logic [plm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import plm_pkg::*;

	plm_cmd_t cmd;
	logic     clr_done;

	// The controller sequences each word; it never sees the payload.
	plm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.clr_done  (clr_done),
		.cmd       (cmd)
	);

	// The datapath holds the link tables, list registers and result.
	plm_datapath #(
		.PAGE_COUNT (PAGE_COUNT),
		.LIST_COUNT (LIST_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_tdata  (s_axis_tdata),
		.out_tdata (m_axis_tdata),
		.clr_done  (clr_done)
	);

endmodule
